// ===== design/cts_pkg.sv =====
`default_nettype none

package cts_pkg;

    // Default table size and the cap on results per dispatch.
    localparam int NUM_TASKS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    // Operation codes.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [7:0] PEND_SAT = 8'hFF;

    // Sequencer step addresses.
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_WALK  = 3'd1;
    localparam logic [2:0] STEP_FLUSH = 3'd2;
    localparam logic [2:0] STEP_FIND  = 3'd3;
    localparam logic [2:0] STEP_DEL   = 3'd4;

    // Jump conditions.
    localparam logic [1:0] JMP_SEQ   = 2'd0;
    localparam logic [1:0] JMP_START = 2'd1;
    localparam logic [1:0] JMP_WALK  = 2'd2;
    localparam logic [1:0] JMP_FIND  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] task_tag;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [7:0]  slot_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [15:0] run_tag;
        logic        removed;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } entry_t;

    typedef struct packed {
        logic ready;
        logic expire;
    } alu_flags_t;

    typedef struct packed {
        logic       busy;
        logic       walk;
        logic       find;
        logic       del;
        logic       flush;
        logic [1:0] jump;
        logic [2:0] next;
    } ctl_word_t;

    // Control store: one word per step.
    function automatic ctl_word_t ucode(input logic [2:0] step);
        ctl_word_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.jump = JMP_START;
                w.next = STEP_IDLE;
            end
            STEP_WALK:
            begin
                w.busy = 1'b1;
                w.walk = 1'b1;
                w.jump = JMP_WALK;
                w.next = STEP_FLUSH;
            end
            STEP_FLUSH:
            begin
                w.busy  = 1'b1;
                w.flush = 1'b1;
                w.jump  = JMP_SEQ;
                w.next  = STEP_IDLE;
            end
            STEP_FIND:
            begin
                w.busy = 1'b1;
                w.find = 1'b1;
                w.jump = JMP_FIND;
                w.next = STEP_IDLE;
            end
            STEP_DEL:
            begin
                w.busy = 1'b1;
                w.del  = 1'b1;
                w.jump = JMP_SEQ;
                w.next = STEP_IDLE;
            end
            default:
            begin
                w.jump = JMP_SEQ;
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic out_word_t make_result(input logic [1:0] status,
                                              input logic [2:0] slot,
                                              input logic [15:0] tag,
                                              input logic removed,
                                              input logic last);
        out_word_t r;
        r.status  = status;
        r.slot    = slot;
        r.run_tag = tag;
        r.removed = removed;
        r.last    = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/cooperative_task_scheduler_core.sv =====
`default_nettype none

// Cooperative time-triggered task scheduler. A word is taken when start is high
// and busy is low; each result word appears on result for exactly one cycle with
// result_valid high and must be captured then, since the receiver cannot stall
// the block. Tick and dispatch walk the whole task table once through the slot
// memory's single read port, one slot per cycle with the write-back of the
// previous slot overlapped. The walk reads the first slot, then updates each slot
// while reading the next, waits for the pipeline to empty and ends with a closing
// step before the next word is accepted. Add searches the used flags one slot per
// cycle from slot zero. Dispatch gives one result per slot with pending runs (at
// most eight, the rest wait for the next dispatch), and the last result of every
// word carries last = 1. Results of one word may be spaced by idle cycles. No
// clearing pass is needed after reset: the used flags clear at reset and a free
// slot's memory contents are never used.
module cooperative_task_scheduler_core #(
    parameter int NUM_TASKS = cts_pkg::NUM_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cts_pkg::in_word_t  item,
    output logic               busy,
    output logic               result_valid,
    output cts_pkg::out_word_t result
);

    import cts_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [CNT_W-1:0]     CNT_END  = CNT_W'(NUM_TASKS);
    localparam logic [IDX_W-1:0]     IDX_LAST = IDX_W'(NUM_TASKS - 1);
    localparam logic [RES_CNT_W-1:0] RES_CAP  = RES_CNT_W'(MAX_RESULTS);

    // Sequencer state.
    logic [2:0]           step_reg, step_next;
    ctl_word_t            ctl;

    // Current word, held for the whole operation.
    in_word_t             item_reg, item_next;

    // Slot walk: cnt_reg is the next slot to read (or the search slot for add);
    // st_* marks the slot whose memory data is arriving this cycle.
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 st_valid_reg, st_valid_next;
    logic [IDX_W-1:0]     st_idx_reg, st_idx_next;

    logic [NUM_TASKS-1:0] used_reg, used_next;

    // Dispatch keeps one result back so that the final one can be marked last.
    logic [RES_CNT_W-1:0] nout_reg, nout_next;
    logic                 held_valid_reg, held_valid_next;
    out_word_t            held_reg, held_next;

    out_word_t            result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    // Slot memory.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t               rd_ent;
    entry_t               alu_upd;
    alu_flags_t           alu_flags;
    entry_t               new_ent;

    logic                 is_tick;
    logic                 walk_done;
    logic [IDX_W-1:0]     find_idx;
    logic                 find_free;
    logic                 find_done;
    logic [IDX_W-1:0]     del_idx;
    logic                 del_ok;
    logic [2:0]           op_target;

    cts_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (NUM_TASKS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent  = entry_t'(ram_rdata);
    assign is_tick = (item_reg.operation == OP_TICK);

    cts_slot_alu u_alu (
        .ent     (rd_ent),
        .is_tick (is_tick),
        .upd     (alu_upd),
        .flags   (alu_flags)
    );

    assign ctl = ucode(step_reg);

    assign walk_done = (cnt_reg == CNT_END) && !st_valid_reg;
    assign find_idx  = cnt_reg[IDX_W-1:0];
    assign find_free = !used_reg[find_idx];
    assign find_done = (item_reg.task_tag == 16'd0) || find_free || (find_idx == IDX_LAST);
    assign del_idx   = item_reg.slot_index[IDX_W-1:0];
    assign del_ok    = ({1'b0, item_reg.slot_index} < 9'(NUM_TASKS)) && used_reg[del_idx];

    // A new add stores the start delay less one, never below zero.
    always_comb
    begin
        new_ent.tag     = item_reg.task_tag;
        new_ent.delay   = (item_reg.start_delay == 32'd0) ? 32'd0
                                                          : item_reg.start_delay - 32'd1;
        new_ent.period  = item_reg.repeat_period;
        new_ent.pending = 8'd0;
    end

    // Entry step of each operation.
    always_comb
    begin
        unique case (item.operation)
            OP_TICK:     op_target = STEP_WALK;
            OP_ADD:      op_target = STEP_FIND;
            OP_DELETE:   op_target = STEP_DEL;
            OP_DISPATCH: op_target = STEP_WALK;
            default:     op_target = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        step_next         = step_reg;
        item_next         = item_reg;
        cnt_next          = cnt_reg;
        st_valid_next     = st_valid_reg;
        st_idx_next       = st_idx_reg;
        used_next         = used_reg;
        nout_next         = nout_reg;
        held_valid_next   = held_valid_reg;
        held_next         = held_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = st_idx_reg;
        ram_wdata         = alu_upd;
        ram_raddr         = cnt_reg[IDX_W-1:0];

        // Table walk for tick and dispatch: read slot cnt_reg while updating the
        // slot read in the previous cycle.
        if (ctl.walk)
        begin
            if (cnt_reg != CNT_END)
            begin
                cnt_next      = cnt_reg + CNT_W'(1);
                st_valid_next = 1'b1;
                st_idx_next   = cnt_reg[IDX_W-1:0];
            end
            else
            begin
                st_valid_next = 1'b0;
            end

            if (st_valid_reg && used_reg[st_idx_reg])
            begin
                if (is_tick)
                begin
                    ram_we = 1'b1;
                end
                else if (alu_flags.ready && (nout_reg != RES_CAP))
                begin
                    ram_we          = 1'b1;
                    nout_next       = nout_reg + RES_CNT_W'(1);
                    held_valid_next = 1'b1;
                    held_next       = make_result(ST_OK, 3'(st_idx_reg), rd_ent.tag,
                                                  alu_flags.expire, 1'b0);
                    if (alu_flags.expire)
                    begin
                        used_next[st_idx_reg] = 1'b0;
                    end
                    if (held_valid_reg)
                    begin
                        result_next       = held_reg;
                        result_valid_next = 1'b1;
                    end
                end
            end
        end

        // Closing result of a walk.
        if (ctl.flush)
        begin
            result_valid_next = 1'b1;
            held_valid_next   = 1'b0;
            if (is_tick)
            begin
                result_next = make_result(ST_OK, 3'd0, 16'd0, 1'b0, 1'b1);
            end
            else if (held_valid_reg)
            begin
                result_next      = held_reg;
                result_next.last = 1'b1;
            end
            else
            begin
                result_next = make_result(ST_NONE, 3'd0, 16'd0, 1'b0, 1'b1);
            end
        end

        // Free-slot search for add, one slot per cycle from slot zero.
        if (ctl.find)
        begin
            if (item_reg.task_tag == 16'd0)
            begin
                result_valid_next = 1'b1;
                result_next       = make_result(ST_FULL, 3'd0, 16'd0, 1'b0, 1'b1);
            end
            else if (find_free)
            begin
                ram_we              = 1'b1;
                ram_waddr           = find_idx;
                ram_wdata           = new_ent;
                used_next[find_idx] = 1'b1;
                result_valid_next   = 1'b1;
                result_next         = make_result(ST_OK, 3'(find_idx), 16'd0, 1'b0, 1'b1);
            end
            else if (find_idx == IDX_LAST)
            begin
                result_valid_next = 1'b1;
                result_next       = make_result(ST_FULL, 3'd0, 16'd0, 1'b0, 1'b1);
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        // Delete only drops the used flag; the memory entry is dead from then on.
        if (ctl.del)
        begin
            result_valid_next = 1'b1;
            if (del_ok)
            begin
                used_next[del_idx] = 1'b0;
                result_next        = make_result(ST_OK, 3'(del_idx), 16'd0, 1'b0, 1'b1);
            end
            else
            begin
                result_next = make_result(ST_BAD_SLOT, 3'd0, 16'd0, 1'b0, 1'b1);
            end
        end

        // Step sequencing.
        unique case (ctl.jump)
            JMP_SEQ:
            begin
                step_next = ctl.next;
            end
            JMP_START:
            begin
                if (start)
                begin
                    step_next       = op_target;
                    item_next       = item;
                    cnt_next        = '0;
                    st_valid_next   = 1'b0;
                    nout_next       = '0;
                    held_valid_next = 1'b0;
                end
            end
            JMP_WALK:
            begin
                if (walk_done)
                begin
                    step_next = ctl.next;
                end
            end
            JMP_FIND:
            begin
                if (find_done)
                begin
                    step_next = ctl.next;
                end
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_IDLE;
            cnt_reg          <= '0;
            st_valid_reg     <= 1'b0;
            used_reg         <= '0;
            nout_reg         <= '0;
            held_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            cnt_reg          <= cnt_next;
            st_valid_reg     <= st_valid_next;
            used_reg         <= used_next;
            nout_reg         <= nout_next;
            held_valid_reg   <= held_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        st_idx_reg <= st_idx_next;
        held_reg   <= held_next;
        result_reg <= result_next;
    end

    assign busy         = ctl.busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/cts_ram.sv =====
`default_nettype none

module cts_ram #(
    parameter int WIDTH  = 88,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/cts_slot_alu.sv =====
`default_nettype none

module cts_slot_alu (
    input  cts_pkg::entry_t     ent,
    input  logic                is_tick,
    output cts_pkg::entry_t     upd,
    output cts_pkg::alu_flags_t flags
);

    import cts_pkg::*;

    logic        delay_zero;
    logic [31:0] dec_src;
    logic [31:0] dec;

    // One shared decrementer: on a tick it reloads from a non-zero period when the
    // delay has run out, and counts the delay down otherwise.
    assign delay_zero = (ent.delay == 32'd0);
    assign dec_src    = (is_tick && delay_zero) ? ent.period : ent.delay;
    assign dec        = dec_src - 32'd1;

    always_comb
    begin
        upd          = ent;
        flags.ready  = (ent.pending != 8'd0);
        flags.expire = 1'b0;
        if (is_tick)
        begin
            if (delay_zero)
            begin
                if (ent.pending != PEND_SAT)
                begin
                    upd.pending = ent.pending + 8'd1;
                end
                if (ent.period != 32'd0)
                begin
                    upd.delay = dec;
                end
            end
            else
            begin
                upd.delay = dec;
            end
        end
        else
        begin
            upd.pending  = ent.pending - 8'd1;
            flags.expire = (ent.period == 32'd0) && (upd.pending == 8'd0) && delay_zero;
        end
    end

endmodule

`default_nettype wire
